[src/signed_int16_to_decimal_ascii_macros.svh]
// assertion macros for the decimal text converter
// every macro expects clk and rst_n in scope
`ifndef SIGNED_INT16_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT16_TO_DECIMAL_ASCII_MACROS_SVH

// condition holds in the same cycle as the trigger
`define S16DA_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("s16da check failed");

// condition holds in the cycle after the trigger
`define S16DA_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("s16da check failed");

`endif

[src/s16da_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s16da_pkg
// shared widths, ascii codes, microcode format and the control store
// ----------------------------------------------------------------------------
package s16da_pkg;

    localparam int VALUE_W    = 16;
    localparam int CHAR_W     = 8;
    localparam int NUM_DIGITS = 5;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int PC_W       = 3;
    localparam int OP_W       = 3;
    localparam int COND_W     = 3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'd57;

    // datapath operations
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_DABBLE = 3'd2;
    localparam logic [OP_W-1:0] OP_SIGN   = 3'd3;
    localparam logic [OP_W-1:0] OP_SKIP   = 3'd4;
    localparam logic [OP_W-1:0] OP_EMIT   = 3'd5;

    // branch conditions
    localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
    localparam logic [COND_W-1:0] C_CNT_NZ    = 3'd2;
    localparam logic [COND_W-1:0] C_LEAD_ZERO = 3'd3;
    localparam logic [COND_W-1:0] C_IDX_NZ    = 3'd4;

    // program steps
    localparam logic [PC_W-1:0] S_LOAD   = 3'd0;
    localparam logic [PC_W-1:0] S_DABBLE = 3'd1;
    localparam logic [PC_W-1:0] S_SIGN   = 3'd2;
    localparam logic [PC_W-1:0] S_SKIP   = 3'd3;
    localparam logic [PC_W-1:0] S_EMIT   = 3'd4;
    localparam logic [PC_W-1:0] S_DONE   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ctl_word_t;

    typedef struct packed {
        logic stall;
        logic cnt_nz;
        logic lead_zero;
        logic idx_nz;
    } seq_status_t;

    // control store: branch to target when cond holds, else fall through
    function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctl_word_t w;
        unique case (pc)
            S_LOAD:   w = '{op: OP_LOAD,   cond: C_ALWAYS,    target: S_DABBLE};
            S_DABBLE: w = '{op: OP_DABBLE, cond: C_CNT_NZ,    target: S_DABBLE};
            S_SIGN:   w = '{op: OP_SIGN,   cond: C_NEVER,     target: S_LOAD};
            S_SKIP:   w = '{op: OP_SKIP,   cond: C_LEAD_ZERO, target: S_SKIP};
            S_EMIT:   w = '{op: OP_EMIT,   cond: C_IDX_NZ,    target: S_EMIT};
            S_DONE:   w = '{op: OP_NOP,    cond: C_ALWAYS,    target: S_LOAD};
            default:  w = '{op: OP_NOP,    cond: C_ALWAYS,    target: S_LOAD};
        endcase
        return w;
    endfunction

endpackage

[src/s16da_value_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s16da_value_if
// input channel carrying one signed 16-bit value per word
// ----------------------------------------------------------------------------
interface s16da_value_if;
    logic                                valid;
    logic                                ready;
    logic signed [s16da_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[src/s16da_char_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s16da_char_if
// output channel carrying one ascii character and its last flag per word
// ----------------------------------------------------------------------------
interface s16da_char_if;
    logic                          valid;
    logic                          ready;
    logic [s16da_pkg::CHAR_W-1:0]  out_char;
    logic                          last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

[src/signed_int16_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// each value is loaded, then run through the 16-step bit-serial double dabble loop,
//   then the sign step and the digit scan that skips leading zeros and emits the
//   digits; loading waits for an input value, and the sign step of a negative value
//   and the emit steps wait while the output register is full and the sink stalls
// the next value is taken only once the last character sits in the output register
// reset: asynchronous active low, clears the step counter, the digit pointer and the output valid
// ----------------------------------------------------------------------------
// signed_int16_to_decimal_ascii
// microcoded signed binary to decimal ascii converter
// ----------------------------------------------------------------------------
`include "signed_int16_to_decimal_ascii_macros.svh"

module signed_int16_to_decimal_ascii
(
    input  logic          clk,
    input  logic          rst_n,
    s16da_value_if.sink   num,
    s16da_char_if.source  text
);

    s16da_pkg::ctl_word_t   ctl;
    s16da_pkg::seq_status_t status;

    logic [s16da_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic [s16da_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [s16da_pkg::BCD_W-1:0]   bcd_reg, bcd_next;
    logic [s16da_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic                          out_valid_reg, out_valid_next;
    logic [s16da_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic                          out_last_reg, out_last_next;

    logic [s16da_pkg::BCD_W-1:0]   bcd_adj;
    logic [s16da_pkg::VALUE_W-1:0] raw;
    logic [3:0]                    top_digit;
    logic                          slot_free;
    logic                          emit_req;
    logic                          do_step;
    logic                          is_minus;
    logic                          char_legal;

    s16da_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    assign raw       = num.value;
    assign top_digit = bcd_reg[s16da_pkg::BCD_W-1 -: 4];
    assign slot_free = !out_valid_reg || text.ready;
    assign emit_req  = (ctl.op == s16da_pkg::OP_EMIT) ||
                       ((ctl.op == s16da_pkg::OP_SIGN) && neg_reg);

    assign status.stall     = ((ctl.op == s16da_pkg::OP_LOAD) && !num.valid) ||
                              (emit_req && !slot_free);
    assign status.cnt_nz    = (cnt_reg != '0);
    assign status.idx_nz    = (idx_reg != '0);
    assign status.lead_zero = (top_digit == 4'd0) && (idx_reg != '0);
    assign do_step          = !status.stall;

    assign num.ready     = (ctl.op == s16da_pkg::OP_LOAD);
    assign text.valid    = out_valid_reg;
    assign text.out_char = out_char_reg;
    assign text.last     = out_last_reg;

    assign is_minus   = (text.out_char == s16da_pkg::ASCII_MINUS);
    assign char_legal = is_minus ||
                        ((text.out_char >= s16da_pkg::ASCII_ZERO) &&
                         (text.out_char <= s16da_pkg::ASCII_NINE));

    // add-3 correction on every bcd digit of 5 or more ahead of the shift
    always_comb
    begin
        for (int d = 0; d < s16da_pkg::NUM_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    always_comb
    begin
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        bcd_next       = bcd_reg;
        idx_next       = idx_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !text.ready;

        if (do_step)
        begin
            case (ctl.op)
                s16da_pkg::OP_LOAD:
                begin
                    neg_next = raw[s16da_pkg::VALUE_W-1];
                    // most negative value wraps to its own unsigned magnitude
                    mag_next = raw[s16da_pkg::VALUE_W-1] ? (~raw + 1'b1) : raw;
                    cnt_next = s16da_pkg::CNT_W'(s16da_pkg::VALUE_W - 1);
                    bcd_next = '0;
                    idx_next = s16da_pkg::IDX_W'(s16da_pkg::NUM_DIGITS - 1);
                end
                s16da_pkg::OP_DABBLE:
                begin
                    bcd_next = {bcd_adj[s16da_pkg::BCD_W-2:0],
                                mag_reg[s16da_pkg::VALUE_W-1]};
                    mag_next = {mag_reg[s16da_pkg::VALUE_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                end
                s16da_pkg::OP_SIGN:
                begin
                    if (neg_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = s16da_pkg::ASCII_MINUS;
                        out_last_next  = 1'b0;
                    end
                end
                s16da_pkg::OP_SKIP:
                begin
                    if (status.lead_zero)
                    begin
                        bcd_next = {bcd_reg[s16da_pkg::BCD_W-5:0], 4'd0};
                        idx_next = idx_reg - 1'b1;
                    end
                end
                s16da_pkg::OP_EMIT:
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = s16da_pkg::ASCII_ZERO + {4'd0, top_digit};
                    out_last_next  = !status.idx_nz;
                    bcd_next       = {bcd_reg[s16da_pkg::BCD_W-5:0], 4'd0};
                    if (status.idx_nz)
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // an accepted value always starts the conversion loop
    `S16DA_ASSERT_NEXT(a_accept_starts_loop, num.valid && num.ready, ctl.op == s16da_pkg::OP_DABBLE)
    // the minus sign never closes a number
    `S16DA_ASSERT_NOW(a_minus_not_last, text.valid && is_minus, !text.last)
    // only a minus sign or a decimal digit leaves the block
    `S16DA_ASSERT_NOW(a_char_range, text.valid, char_legal)
    // digit pointer stays inside the bcd register
    `S16DA_ASSERT_NOW(a_idx_range, 1'b1, idx_reg <= s16da_pkg::IDX_W'(s16da_pkg::NUM_DIGITS - 1))

endmodule

[src/s16da_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s16da_seq
// step counter and control store; issues one control word per cycle
// ----------------------------------------------------------------------------
module s16da_seq
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  s16da_pkg::seq_status_t status,
    output s16da_pkg::ctl_word_t   ctl
);

    logic [s16da_pkg::PC_W-1:0] pc_reg;
    logic [s16da_pkg::PC_W-1:0] pc_next;
    logic                       taken;

    assign ctl = s16da_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            s16da_pkg::C_NEVER:     taken = 1'b0;
            s16da_pkg::C_ALWAYS:    taken = 1'b1;
            s16da_pkg::C_CNT_NZ:    taken = status.cnt_nz;
            s16da_pkg::C_LEAD_ZERO: taken = status.lead_zero;
            s16da_pkg::C_IDX_NZ:    taken = status.idx_nz;
            default:                taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (status.stall)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = ctl.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= s16da_pkg::S_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[tb/signed_int16_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int16_to_decimal_ascii_tb
// feeds signed 16-bit words into the converter and checks every ascii character
// and last flag it sends back against a decimal rendering worked out here
// ----------------------------------------------------------------------------
module signed_int16_to_decimal_ascii_tb;

    localparam int CLK_HALF      = 5;
    localparam int DECIMAL_BASE  = 10;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 30;
    localparam int RANDOM_WORDS  = 130;
    localparam int CALM_WORDS    = 30;
    localparam int HOLD_AT       = 60;
    localparam int DRAIN_AT      = 70;
    localparam int NUM_ROWS      = 20;

    typedef struct {
        logic [s16da_pkg::CHAR_W-1:0] ch;
        logic                         last;
    } char_word_t;

    typedef struct {
        logic signed [s16da_pkg::VALUE_W-1:0] value;
        string                                text;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n;

    s16da_value_if num_if ();
    s16da_char_if  text_if ();

    char_word_t pending_chars [$];

    int mismatches      = 0;
    int words_sent      = 0;
    int negatives_sent  = 0;
    int chars_checked   = 0;
    int idle_cycles     = 0;
    int sink_stall_left = 0;
    bit gaps_on         = 1'b1;
    bit sink_bursts_on  = 1'b1;
    bit hold_request    = 1'b0;

    // empty text: expectation comes from render_decimal
    table_row_t directed_rows [NUM_ROWS] = '{
        '{0, "0"},           '{1, "1"},          '{-1, "-1"},         '{9, "9"},
        '{10, "10"},         '{-10, "-10"},      '{99, ""},           '{100, "100"},
        '{1000, "1000"},     '{-1001, ""},       '{9999, ""},         '{10000, "10000"},
        '{-10000, "-10000"}, '{10203, ""},       '{32767, "32767"},   '{-32767, "-32767"},
        '{-32768, "-32768"}, '{21845, ""},       '{-21846, ""},       '{12345, "12345"}
    };

    signed_int16_to_decimal_ascii dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_if),
        .text  (text_if)
    );

    always #CLK_HALF clk = ~clk;

    // decimal text of one value, minus sign first, no leading zeros
    function automatic void render_decimal(input logic signed [s16da_pkg::VALUE_W-1:0] v);
        logic [s16da_pkg::VALUE_W:0] mag;
        logic [3:0]                  digits [s16da_pkg::NUM_DIGITS];
        int                          nd;
        mag = v[s16da_pkg::VALUE_W-1] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
        nd  = 0;
        do
        begin
            digits[nd] = 4'(mag % DECIMAL_BASE);
            mag        = 17'(mag / DECIMAL_BASE);
            nd++;
        end
        while (mag != 0);
        if (v[s16da_pkg::VALUE_W-1])
            pending_chars.push_back('{s16da_pkg::ASCII_MINUS, 1'b0});
        for (int k = nd - 1; k >= 0; k--)
            pending_chars.push_back('{s16da_pkg::ASCII_ZERO + s16da_pkg::CHAR_W'(digits[k]),
                                      k == 0});
    endfunction

    function automatic void expect_text(input string s);
        for (int i = 0; i < s.len(); i++)
            pending_chars.push_back('{s[i], i == s.len() - 1});
    endfunction

    function automatic logic signed [s16da_pkg::VALUE_W-1:0] pick_value();
        int tmp;
        case ($urandom_range(0, 3))
            0: tmp = int'($urandom);
            1: tmp = int'($urandom_range(0, 198)) - 99;
            2:
            begin
                // around a power of ten, either sign
                tmp = DECIMAL_BASE ** int'($urandom_range(0, 4)) +
                      int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1) == 1)
                    tmp = -tmp;
            end
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                    tmp = 32767 - int'($urandom_range(0, 3));
                else
                    tmp = -32768 + int'($urandom_range(0, 3));
            end
        endcase
        return s16da_pkg::VALUE_W'(tmp);
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic send_word(input logic signed [s16da_pkg::VALUE_W-1:0] v,
                             input string text);
        num_if.valid <= 1'b1;
        num_if.value <= v;
        do
            @(posedge clk);
        while (!num_if.ready);
        words_sent++;
        if (v < 0)
            negatives_sent++;
        if (text.len() != 0)
            expect_text(text);
        else
            render_decimal(v);
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            num_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // sender pauses until every character owed has come out
    task automatic wait_drain();
        num_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_chars.size() != 0);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        text_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                text_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (!sink_bursts_on)
                text_if.ready <= 1'b1;
            else if (sink_stall_left > 0)
            begin
                text_if.ready <= 1'b0;
                sink_stall_left--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                text_if.ready   <= 1'b0;
                sink_stall_left = $urandom_range(0, 14);
            end
            else
                text_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        char_word_t want;
        if (rst_n && text_if.valid && text_if.ready)
        begin
            chars_checked++;
            if (pending_chars.size() == 0)
                flag_mismatch($sformatf("unexpected char %0d last %0b",
                                        text_if.out_char, text_if.last));
            else
            begin
                want = pending_chars.pop_front();
                if (text_if.out_char !== want.ch)
                    flag_mismatch($sformatf("out_char %0d, want %0d",
                                            text_if.out_char, want.ch));
                if (text_if.last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b on char %0d",
                                            text_if.last, want.last, want.ch));
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge clk)
    begin
        if ((num_if.valid && num_if.ready) || (text_if.valid && text_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("signed_int16_to_decimal_ascii_tb NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        num_if.valid = 1'b0;
        num_if.value = '0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            maybe_gap();
            send_word(directed_rows[i].value, directed_rows[i].text);
        end
        wait_drain();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // long receiver hold-off while words keep coming, then a full drain
            if (i == HOLD_AT)
                hold_request = 1'b1;
            if (i == DRAIN_AT)
                wait_drain();
            if (i == RANDOM_WORDS - CALM_WORDS)
            begin
                gaps_on        = 1'b0;
                sink_bursts_on = 1'b0;
            end
            maybe_gap();
            send_word(pick_value(), "");
        end
        num_if.valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d values converted (%0d negative, both extremes), %0d characters compared",
                 words_sent, negatives_sent, chars_checked);
        $display("random idling on both sides, one %0d-cycle receiver hold-off, last %0d %s",
                 HOLD_CYCLES, CALM_WORDS, "back to back");
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("signed_int16_to_decimal_ascii_tb OK");
        else
            $display("signed_int16_to_decimal_ascii_tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/s16da_pkg.sv
src/s16da_value_if.sv
src/s16da_char_if.sv
src/s16da_seq.sv
src/signed_int16_to_decimal_ascii.sv
tb/signed_int16_to_decimal_ascii_tb.sv
